>>> rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared definitions for the LRU key/value cache
// Widths, register map, operation codes and the per-cell status record.
// ----------------------------------------------------------------------------
package lkv_pkg;

  // Default sizing of the cell row and the stored key.
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_BITS_DEF    = 32;

  // Fixed payload widths.
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  // Configuration port layout: one 32-bit register at byte address 0.
  localparam int                ADDR_W       = 3;
  localparam logic              REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0]  CAP_RESET    = 5'd16;

  // Request operation codes.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Value returned by a get that misses.
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  // Status that every cell reports to the controller.
  typedef struct packed {
    logic valid;
    logic match;
  } cell_stat_t;

endpackage

>>> rtl/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell: one position of the recency-ordered cell row
// Holds one key/value pair, compares its key against the request and loads
// the contents of its more recent neighbor when told to shift.
// ----------------------------------------------------------------------------
module lkv_cell #(
  parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic [KEY_BITS-1:0]       lookup,
  input  logic [KEY_BITS-1:0]       prev_key,
  input  logic [lkv_pkg::DATA_W-1:0] prev_value,
  input  logic                      prev_valid,
  output logic [KEY_BITS-1:0]       key,
  output logic [lkv_pkg::DATA_W-1:0] value,
  output lkv_pkg::cell_stat_t       stat
);

  logic valid;

  // Occupancy follows the neighbor on a shift; reset empties the cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid;
    end
  end

  // Payload moves one position toward the least recent end.
  always_ff @(posedge clk) begin
    if (shift) begin
      key   <= prev_key;
      value <= prev_value;
    end
  end

  // Tag compare against the broadcast request key.
  assign stat.valid = valid;
  assign stat.match = valid && (key == lookup);

endmodule

>>> rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache with LRU replacement
//
//   channel   ports                                          direction
//   request   start, busy, operation, lookup_key, write_value   in/out
//   result    done, hit, read_value, evicted, evicted_key       out
//   config    psel, penable, pwrite, paddr, pwdata, prdata,     in/out
//             pready
//
// A request is taken on any cycle where start is high and busy is low, one
// request per clock. Its result appears with done in the following cycle.
// The key compare and shift of the cell row both complete in the accepting cycle.
// Reset clears all valid marks and the fill count; no clearing pass is needed.
// busy is high only during reset. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = lkv_pkg::KEY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Request channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              operation,
  input  logic signed [lkv_pkg::DATA_W-1:0] lookup_key,
  input  logic signed [lkv_pkg::DATA_W-1:0] write_value,
  // Result channel
  output logic                              done,
  output logic                              hit,
  output logic signed [lkv_pkg::DATA_W-1:0] read_value,
  output logic                              evicted,
  output logic signed [lkv_pkg::DATA_W-1:0] evicted_key,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lkv_pkg::ADDR_W-1:0]        paddr,
  input  logic [lkv_pkg::DATA_W-1:0]        pwdata,
  output logic [lkv_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

  logic [lkv_pkg::CAP_W-1:0] capacity;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;

  logic                      accept;
  logic                      is_put;
  logic [KEY_BITS-1:0]       req_key;
  logic [lkv_pkg::DATA_W-1:0] new_value;
  logic [lkv_pkg::DATA_W-1:0] hit_value;
  logic [KEY_BITS-1:0]       last_key;
  logic signed [KEY_BITS-1:0] last_key_s;
  logic                      any_hit;
  logic                      evict;
  logic [CW-1:0]             count_w;
  logic [CW-1:0]             eff_cap;
  logic [CW-1:0]             last_pos;
  logic [CW-1:0]             ins_pos;

  logic [KEY_BITS-1:0]        cell_key   [MAX_ENTRIES];
  logic [lkv_pkg::DATA_W-1:0] cell_value [MAX_ENTRIES];
  lkv_pkg::cell_stat_t        cell_stat  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]     match_vec;
  logic [MAX_ENTRIES-1:0]     valid_vec;
  logic [MAX_ENTRIES-1:0]     valid_inc;
  logic [MAX_ENTRIES-1:0]     shift_vec;
  logic [MAX_ENTRIES:0]       tail_hit;

  // Request acceptance and decode.
  assign busy      = rst;
  assign accept    = start && !busy;
  assign is_put    = (operation == lkv_pkg::OP_PUT);
  assign req_key   = lookup_key[KEY_BITS-1:0];
  assign any_hit   = |match_vec;
  assign new_value = is_put ? write_value : hit_value;

  // Effective capacity: zero acts as one, large values clamp to the row size.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(capacity) > CW'(MAX_ENTRIES)) begin
      eff_cap = CW'(MAX_ENTRIES);
    end else begin
      eff_cap = CW'(capacity);
    end
  end

  // Entries occupy positions 0 to count-1, most recent first.
  assign count_w  = CW'(count);
  assign last_pos = count_w - CW'(1);
  assign evict    = is_put && !any_hit && (count_w >= eff_cap) && (count != '0);
  assign ins_pos  = evict ? last_pos : count_w;

  // Hit data and the key at the least recent position.
  always_comb begin
    hit_value = '0;
    last_key  = '0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      if (match_vec[j]) begin
        hit_value = hit_value | cell_value[j];
      end
      if (CW'(j) == last_pos) begin
        last_key = last_key | cell_key[j];
      end
    end
  end
  assign last_key_s = last_key;

  // The cell row: each cell loads from its more recent neighbor on a shift.
  assign tail_hit[MAX_ENTRIES] = 1'b0;
  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
    logic [KEY_BITS-1:0]        prev_key;
    logic [lkv_pkg::DATA_W-1:0] prev_value;
    logic                       prev_valid;

    assign match_vec[j] = cell_stat[j].match;
    assign valid_vec[j] = cell_stat[j].valid;
    assign tail_hit[j]  = match_vec[j] | tail_hit[j+1];

    // A hit moves the entries in front of the match; an insert opens ins_pos.
    assign shift_vec[j] = accept &&
                          (any_hit ? tail_hit[j] : (is_put && (CW'(j) <= ins_pos)));

    if (j == 0) begin : g_head
      assign prev_key   = req_key;
      assign prev_value = new_value;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_key   = cell_key[j-1];
      assign prev_value = cell_value[j-1];
      assign prev_valid = cell_stat[j-1].valid;
    end

    lkv_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (shift_vec[j]),
      .lookup     (req_key),
      .prev_key   (prev_key),
      .prev_value (prev_value),
      .prev_valid (prev_valid),
      .key        (cell_key[j]),
      .value      (cell_value[j]),
      .stat       (cell_stat[j])
    );
  end

  // Fill count grows on an insert that evicts nothing.
  always_comb begin
    count_next = count;
    if (accept && is_put && !any_hit && !evict) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result register, valid for exactly one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit     <= any_hit;
      evicted <= evict;
      if (is_put) begin
        read_value <= '0;
      end else if (any_hit) begin
        read_value <= hit_value;
      end else begin
        read_value <= lkv_pkg::MISS_VALUE;
      end
      if (evict) begin
        evicted_key <= lkv_pkg::DATA_W'(last_key_s);
      end else begin
        evicted_key <= '0;
      end
    end
  end

  // Configuration register: capacity at byte address 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkv_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == lkv_pkg::REG_CAPACITY)) begin
      capacity <= pwdata[lkv_pkg::CAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == lkv_pkg::REG_CAPACITY) ?
                  lkv_pkg::DATA_W'(capacity) : '0;

  // Checks on the cell row and the result timing.
  assign valid_inc = valid_vec + MAX_ENTRIES'(1);

  a_unique_key: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("more than one cell matches the request key");

  a_packed_row: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & valid_inc) == '0)
    else $error("valid cells are not packed at the most recent end");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("fill count disagrees with the valid cells");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted request produced no result");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    done && evicted |-> !hit && $past(count) != '0)
    else $error("eviction reported on a hit or from an empty row");

endmodule
